>>> src/sdq_pkg.sv
// Shared types, constants and ring helpers for the deque engine.
package sdq_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = IDX_W + 1;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_READ_OUT   = 3'd4,
        MODE_SORT       = 3'd5,
        MODE_DEDUPE     = 3'd6,
        MODE_UNUSED     = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_RO_RD,
        S_RO_OUT,
        S_SO_I,
        S_SO_A,
        S_SO_J,
        S_SO_C,
        S_DD_I,
        S_DD_X,
        S_DD_J,
        S_DD_C
    } t_state;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        if (base == '0) begin
            return IDX_W'(CAPACITY - 1);
        end
        return base - 1'b1;
    endfunction

endpackage

>>> src/sdq_req_if.sv
// Request channel: command mode and push value.
interface sdq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

>>> src/sdq_rsp_if.sv
// Response channel: result value, status and last flag.
interface sdq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output result_value, output status, output last,
                    input ready);
    modport sink (input valid, input result_value, input status, input last,
                  output ready);
endinterface

>>> src/sdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/sdq_cmp.sv
// Shared signed magnitude and equality compare unit.
module sdq_cmp
    import sdq_pkg::*;
(
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_cmp              o_cmp
);
    always_comb begin
        o_cmp.gt = $signed(i_a) > $signed(i_b);
        o_cmp.eq = i_a == i_b;
    end
endmodule

>>> src/sortable_deque_engine.sv
// Top level: deque over a ring RAM, with a sequencer that sorts and dedupes in place.
// Push: RAM write, then result load. Pop: RAM read, then result load.
// Read out: one RAM read per element, then its result load.
// Sort and dedupe run on one compare unit.
// Request ready only in idle; a waiting result does not block the next request.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module sortable_deque_engine
    import sdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdq_req_if.sink   i_req,
    sdq_rsp_if.source o_rsp
);
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [OCC_W-1:0]  r_i, n_i;
    logic [OCC_W-1:0]  r_j, n_j;
    logic [OCC_W-1:0]  r_n, n_n;
    logic [DATA_W-1:0] r_a, n_a;
    t_status           r_status, n_status;
    logic              r_use_rdata, n_use_rdata;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    t_cmp              cmp;

    logic              w_accept, w_out_free, w_full, w_empty;
    t_mode             w_mode;

    sdq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sdq_cmp u_cmp (
        .i_a   (r_a),
        .i_b   (ram_rdata),
        .o_cmp (cmp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_mode      = t_mode'(i_req.mode);
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_full      = (r_occ == OCC_W'(CAPACITY));
    assign w_empty     = (r_occ == '0);

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.last         = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_j          <= n_j;
        r_n          <= n_n;
        r_a          <= n_a;
        r_status     <= n_status;
        r_use_rdata  <= n_use_rdata;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_occ        = r_occ;
        n_i          = r_i;
        n_j          = r_j;
        n_n          = r_n;
        n_a          = r_a;
        n_status     = r_status;
        n_use_rdata  = r_use_rdata;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = ring_pos(r_front, r_i);
        ram_raddr    = ring_pos(r_front, r_i);
        ram_wdata    = r_a;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status    = ST_OK;
                    n_use_rdata = 1'b0;
                    n_i         = '0;
                    n_n         = '0;
                    case (w_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            n_state = S_EMIT;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_req.value;
                                n_occ     = r_occ + 1'b1;
                                if (w_mode == MODE_PUSH_FRONT) begin
                                    n_front   = ring_dec(r_front);
                                    ram_waddr = ring_dec(r_front);
                                end else begin
                                    ram_waddr = ring_pos(r_front, r_occ);
                                end
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            n_state = S_EMIT;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_re      = 1'b1;
                                n_use_rdata = 1'b1;
                                n_occ       = r_occ - 1'b1;
                                if (w_mode == MODE_POP_FRONT) begin
                                    ram_raddr = r_front;
                                    n_front   = ring_pos(r_front, OCC_W'(1));
                                end else begin
                                    ram_raddr = ring_pos(r_front, r_occ - 1'b1);
                                end
                            end
                        end
                        MODE_READ_OUT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_RO_RD;
                            end
                        end
                        MODE_SORT: begin
                            n_state = S_SO_I;
                        end
                        MODE_DEDUPE: begin
                            n_state = S_DD_I;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_use_rdata ? ram_rdata : '0;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            S_RO_RD: begin
                ram_re  = 1'b1;
                n_state = S_RO_OUT;
            end

            S_RO_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = ram_rdata;
                    n_out_status = ST_OK;
                    n_out_last   = (r_i + 1'b1 == r_occ);
                    n_i          = r_i + 1'b1;
                    n_state      = (r_i + 1'b1 == r_occ) ? S_IDLE : S_RO_RD;
                end
            end

            S_SO_I: begin
                if (r_i >= r_occ) begin
                    n_state = S_EMIT;
                end else begin
                    ram_re  = 1'b1;
                    n_j     = r_i + 1'b1;
                    n_state = S_SO_A;
                end
            end

            S_SO_A: begin
                n_a     = ram_rdata;
                n_state = S_SO_J;
            end

            S_SO_J: begin
                if (r_j >= r_occ) begin
                    ram_we  = 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_SO_I;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_pos(r_front, r_j);
                    n_state   = S_SO_C;
                end
            end

            S_SO_C: begin
                if (cmp.gt) begin
                    ram_we    = 1'b1;
                    ram_waddr = ring_pos(r_front, r_j);
                    n_a       = ram_rdata;
                end
                n_j     = r_j + 1'b1;
                n_state = S_SO_J;
            end

            S_DD_I: begin
                if (r_i >= r_occ) begin
                    n_occ   = r_n;
                    n_state = S_EMIT;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_DD_X;
                end
            end

            S_DD_X: begin
                n_a     = ram_rdata;
                n_j     = '0;
                n_state = S_DD_J;
            end

            S_DD_J: begin
                if (r_j >= r_n) begin
                    ram_we    = 1'b1;
                    ram_waddr = ring_pos(r_front, r_n);
                    n_n       = r_n + 1'b1;
                    n_i       = r_i + 1'b1;
                    n_state   = S_DD_I;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_pos(r_front, r_j);
                    n_state   = S_DD_C;
                end
            end

            S_DD_C: begin
                if (cmp.eq) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_DD_I;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DD_J;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> src/sdq_chk.sv
// Port-level assertions for the deque engine, bound to the top level.
module sdq_chk
    import sdq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [2:0]  i_req_mode,
    input logic        o_rsp_valid,
    input logic        o_rsp_ready,
    input logic [31:0] o_rsp_result_value,
    input logic [1:0]  o_rsp_status,
    input logic        o_rsp_last
);
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_mode != MODE_UNUSED) |=> !i_req_ready)
        else $error("ready held high after a request was taken");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp_status != ST_OK) |-> o_rsp_last)
        else $error("error status on a response that is not last");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp_status != ST_OK) |-> (o_rsp_result_value == '0))
        else $error("error status with nonzero value");

    a_no_rsvd_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp_status != ST_RSVD))
        else $error("reserved status code on response");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_result_value)
            && $stable(o_rsp_status) && $stable(o_rsp_last))
        else $error("stalled response changed");
endmodule

bind sortable_deque_engine sdq_chk u_sdq_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_req_mode         (i_req.mode),
    .o_rsp_valid        (o_rsp.valid),
    .o_rsp_ready        (o_rsp.ready),
    .o_rsp_result_value (o_rsp.result_value),
    .o_rsp_status       (o_rsp.status),
    .o_rsp_last         (o_rsp.last)
);

>>> tb/sortable_deque_engine_test.sv
// Self-checking regression for the deque engine: directed corner cases, random traffic, stalls.
module sortable_deque_engine_test
    import sdq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 18;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     last;
    } t_deque_result;

    logic i_clk;
    logic i_rst_n;

    sdq_req_if req_if();
    sdq_rsp_if rsp_if();

    sortable_deque_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic signed [DATA_W-1:0] deque_contents[$];
    t_deque_result            pending_results[$];

    int   mismatch_count = 0;
    int   stall_cycles   = 0;
    int   send_idle_pct  = 0;
    int   rsp_stall_pct  = 0;
    logic rsp_hold       = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void expect_result(input t_deque_result res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic void apply_command(input t_mode mode,
                                          input logic signed [DATA_W-1:0] value);
        t_deque_result            res;
        logic signed [DATA_W-1:0] tmp;
        logic signed [DATA_W-1:0] kept[$];
        bit                       seen;
        int                       j;
        res.value  = '0;
        res.status = ST_OK;
        res.last   = 1'b1;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (deque_contents.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (mode == MODE_PUSH_FRONT) begin
                    deque_contents.insert(0, value);
                end else begin
                    deque_contents.insert(deque_contents.size(), value);
                end
                expect_result(res);
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (deque_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (mode == MODE_POP_FRONT) begin
                    res.value = deque_contents[0];
                    deque_contents.delete(0);
                end else begin
                    res.value = deque_contents[deque_contents.size() - 1];
                    deque_contents.delete(deque_contents.size() - 1);
                end
                expect_result(res);
            end
            MODE_READ_OUT: begin
                if (deque_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                    expect_result(res);
                end else begin
                    for (int i = 0; i < deque_contents.size(); i++) begin
                        res.value = deque_contents[i];
                        res.last  = (i == deque_contents.size() - 1);
                        expect_result(res);
                    end
                end
            end
            MODE_SORT: begin
                for (int i = 1; i < deque_contents.size(); i++) begin
                    tmp = deque_contents[i];
                    j   = i;
                    while (j > 0 && deque_contents[j-1] > tmp) begin
                        deque_contents[j] = deque_contents[j-1];
                        j--;
                    end
                    deque_contents[j] = tmp;
                end
                expect_result(res);
            end
            MODE_DEDUPE: begin
                foreach (deque_contents[i]) begin
                    seen = 1'b0;
                    foreach (kept[k]) begin
                        if (kept[k] == deque_contents[i]) begin
                            seen = 1'b1;
                        end
                    end
                    if (!seen) begin
                        kept.insert(kept.size(), deque_contents[i]);
                    end
                end
                deque_contents = kept;
                expect_result(res);
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return DATA_W'($signed($urandom_range(7)) - 4);
        end else if (pick < 50) begin
            return pick[0] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return $urandom;
    endfunction

    task automatic send_request(input t_mode mode, input logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.value <= value;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        apply_command(mode, value);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    task automatic set_idle_phase(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        rsp_stall_pct <= stall_pct;
    endtask

    task automatic test_empty_queue();
        send_request(MODE_POP_FRONT, random_value());
        send_request(MODE_POP_BACK, random_value());
        send_request(MODE_READ_OUT, random_value());
        send_request(MODE_SORT, random_value());
        send_request(MODE_DEDUPE, random_value());
        send_request(MODE_UNUSED, random_value());
        wait_drained();
    endtask

    task automatic test_extreme_values();
        send_request(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_request(MODE_PUSH_BACK, 32'sh0000_0000);
        send_request(MODE_PUSH_FRONT, 32'shFFFF_FFFF);
        send_request(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(MODE_PUSH_BACK, 32'sh0000_0001);
        send_request(MODE_READ_OUT, '0);
        send_request(MODE_SORT, '0);
        send_request(MODE_READ_OUT, '0);
        send_request(MODE_DEDUPE, '0);
        send_request(MODE_READ_OUT, '0);
        while (deque_contents.size() != 0) begin
            send_request(deque_contents.size() % 2 ? MODE_POP_FRONT : MODE_POP_BACK, '0);
        end
        send_request(MODE_POP_BACK, '0);
        wait_drained();
    endtask

    task automatic test_full_queue();
        while (deque_contents.size() != 0) begin
            send_request(MODE_POP_FRONT, random_value());
        end
        for (int i = 0; i < CAPACITY; i++) begin
            send_request($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, random_value());
        end
        send_request(MODE_PUSH_FRONT, random_value());
        send_request(MODE_PUSH_BACK, random_value());
        send_request(MODE_READ_OUT, random_value());
        send_request(MODE_SORT, random_value());
        send_request(MODE_READ_OUT, random_value());
        send_request(MODE_DEDUPE, random_value());
        send_request(MODE_READ_OUT, random_value());
        while (deque_contents.size() != 0) begin
            send_request(MODE_POP_BACK, random_value());
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int item_count);
        int    sent;
        int    pick;
        t_mode mode;
        sent = 0;
        while (sent < item_count) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                mode = MODE_PUSH_FRONT;
            end else if (pick < 50) begin
                mode = MODE_PUSH_BACK;
            end else if (pick < 62) begin
                mode = MODE_POP_FRONT;
            end else if (pick < 74) begin
                mode = MODE_POP_BACK;
            end else if (pick < 82) begin
                mode = MODE_READ_OUT;
            end else if (pick < 88) begin
                mode = MODE_SORT;
            end else if (pick < 95) begin
                mode = MODE_DEDUPE;
            end else begin
                mode = MODE_UNUSED;
            end
            send_request(mode, random_value());
            if (mode != MODE_UNUSED) begin
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++) begin
            send_request(i % 3 == 2 ? MODE_POP_FRONT : MODE_PUSH_BACK, random_value());
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: value %0d status %0d last %0b",
                             rsp_if.result_value, rsp_if.status, rsp_if.last);
                end
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (rsp_if.result_value !== want.value || rsp_if.status !== want.status ||
                    rsp_if.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"result mismatch: expected value %0d status %0d last %0b,",
                                  " got value %0d status %0d last %0b"},
                                 want.value, want.status, want.last,
                                 rsp_if.result_value, rsp_if.status, rsp_if.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.mode  = MODE_PUSH_FRONT;
        req_if.value = '0;
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idle_phase(0, 0);
        test_empty_queue();
        test_extreme_values();
        test_full_queue();
        test_random_traffic(PHASE_ITEMS);
        set_idle_phase(86, 0);
        test_random_traffic(PHASE_ITEMS);
        set_idle_phase(0, 86);
        test_random_traffic(PHASE_ITEMS);
        set_idle_phase(6, 6);
        test_random_traffic(PHASE_ITEMS);
        set_idle_phase(0, 0);
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
